### rtl/bbox_side_quantizer_macros.svh
// ----------------------------------------------------------------------------
// bbox_side_quantizer_macros.svh
// assertion macros shared by the quantizer rtl
// ----------------------------------------------------------------------------
`ifndef BBOX_SIDE_QUANTIZER_MACROS_SVH
`define BBOX_SIDE_QUANTIZER_MACROS_SVH

// check on every edge outside reset
`define BSQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every edge, reset included
`define BSQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/bsq_pkg.sv
// ----------------------------------------------------------------------------
// bsq_pkg
// types and constants of the bounding box side quantizer
// ----------------------------------------------------------------------------
package bsq_pkg;

  localparam int CoordBits  = 16;
  localparam int UnitRound  = 15;
  localparam int UnitShift  = 4;                 // divide by 16
  localparam int CountBits  = 4;
  localparam int CountMax   = 15;
  localparam int CodeBits   = 2 * CountBits;
  // largest unit is (2^W - 1 + 15) / 16 = 2^(W-4), needs W-3 bits
  localparam int UnitBits   = CoordBits - UnitShift + 1;
  localparam int CmpBits    = CoordBits + 1;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic        [CoordBits-1:0] dist_t;
  typedef logic        [UnitBits-1:0]  unit_t;
  typedef logic        [CountBits-1:0] count_t;

  typedef struct packed {
    coord_t outer_neg;
    coord_t outer_pos;
    coord_t child_neg;
    coord_t child_pos;
  } in_word_t;

  typedef struct packed {
    logic [CodeBits-1:0] side_code;
    coord_t              snapped_neg;
    coord_t              snapped_pos;
  } out_word_t;

  // word handed from cell to cell
  typedef struct packed {
    unit_t  unit;
    dist_t  rem_neg;
    dist_t  rem_pos;
    count_t cnt_neg;
    count_t cnt_pos;
    coord_t child_neg;
    coord_t child_pos;
  } cell_word_t;

endpackage

### rtl/bbox_side_quantizer.sv
// ----------------------------------------------------------------------------
// bbox_side_quantizer
// quantizes one axis of a child box against its parent box
// ----------------------------------------------------------------------------
// One word in, one word out, one word per cycle while the output is not
// stalled. A front stage works out the unit ((parent span + 15) / 16) and the
// inward distance of each child corner, then a chain of four cells each
// settles one quotient bit (8, 4, 2, 1 units) of both corners by a
// compare-and-subtract, handing the partial remainder to the next cell.
// The greedy bit search saturates at 15 on its own. Since the remainder left
// over is exactly distance minus count times unit, the snapped corners are
// child_neg - rem and child_pos + rem, with no multiplier. A corner on or
// outside the parent enters with a zero remainder, and a parent whose span is
// not positive also brings a unit of one, so the count is zero and the corner
// passes through. Each stage stalls only when it holds a word and the next one
// is stalled, so bubbles close up behind a stalled output.
// ----------------------------------------------------------------------------
`include "bbox_side_quantizer_macros.svh"

module bbox_side_quantizer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bsq_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output bsq_pkg::out_word_t out_word
);

  localparam int W     = bsq_pkg::CoordBits;
  localparam int Cells = bsq_pkg::CountBits;

  // chain links: index 0 is the front stage output, Cells is the last cell
  logic                chain_valid [Cells+1];
  logic                chain_stall [Cells+1];
  bsq_pkg::cell_word_t chain_word  [Cells+1];

  logic signed [W:0]   snap_neg;
  logic signed [W:0]   snap_pos;

  // leftover checks on the last cell
  logic                rem_neg_ok;
  logic                rem_pos_ok;

  // front stage: unit and inward distances
  bsq_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_word  (in_word),
    .dn_valid (chain_valid[0]),
    .dn_stall (chain_stall[0]),
    .dn_word  (chain_word[0])
  );

  // one cell per count bit, most significant first
  for (genvar i = 0; i < Cells; i++) begin : g_cell
    bsq_cell #(
      .Bit (Cells - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_valid[i]),
      .up_stall (chain_stall[i]),
      .up_word  (chain_word[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_stall (chain_stall[i+1]),
      .dn_word  (chain_word[i+1])
    );
  end

  // last cell register doubles as the output register
  assign chain_stall[Cells] = out_stall;
  assign out_valid          = chain_valid[Cells];

  // remainder left over gives the snapped corner directly
  always_comb begin
    snap_neg = {chain_word[Cells].child_neg[W-1], chain_word[Cells].child_neg}
             - {1'b0, chain_word[Cells].rem_neg};
    snap_pos = {chain_word[Cells].child_pos[W-1], chain_word[Cells].child_pos}
             + {1'b0, chain_word[Cells].rem_pos};

    out_word.side_code   = {chain_word[Cells].cnt_pos, chain_word[Cells].cnt_neg};
    out_word.snapped_neg = snap_neg[W-1:0];
    out_word.snapped_pos = snap_pos[W-1:0];
  end

  // leftover is below one unit unless the count saturated
  assign rem_neg_ok = ({1'b0, chain_word[Cells].rem_neg} < (W+1)'(chain_word[Cells].unit))
                   || (chain_word[Cells].cnt_neg
                       == bsq_pkg::CountBits'(bsq_pkg::CountMax));
  assign rem_pos_ok = ({1'b0, chain_word[Cells].rem_pos} < (W+1)'(chain_word[Cells].unit))
                   || (chain_word[Cells].cnt_pos
                       == bsq_pkg::CountBits'(bsq_pkg::CountMax));

  // pipeline is empty right after reset
  `BSQ_ASSERT_ALWAYS(a_empty_after_reset, !rst_n |=> !out_valid, "output valid after reset")

  // an accepted word lands in the front stage
  `BSQ_ASSERT(a_accept_lands, in_valid && !in_stall |=> chain_valid[0], "accepted word lost")

  `BSQ_ASSERT(a_rem_neg_bound, out_valid |-> rem_neg_ok, "lower remainder not reduced")

  `BSQ_ASSERT(a_rem_pos_bound, out_valid |-> rem_pos_ok, "upper remainder not reduced")

endmodule

### rtl/bsq_prep.sv
// ----------------------------------------------------------------------------
// bsq_prep
// front stage: unit size and inward distances of both child corners
// ----------------------------------------------------------------------------
module bsq_prep (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_stall,
  input  bsq_pkg::in_word_t   up_word,
  output logic                dn_valid,
  input  logic                dn_stall,
  output bsq_pkg::cell_word_t dn_word
);

  localparam int W = bsq_pkg::CoordBits;

  logic                valid_r;
  logic                valid_nxt;
  bsq_pkg::cell_word_t word_r;
  bsq_pkg::cell_word_t word_nxt;

  logic signed [W:0]   span;
  logic signed [W+1:0] span_rnd;
  logic signed [W:0]   dist_neg;
  logic signed [W:0]   dist_pos;
  logic                span_ok;
  logic                neg_in;
  logic                pos_in;

  always_comb begin
    span     = {up_word.outer_pos[W-1], up_word.outer_pos}
             - {up_word.outer_neg[W-1], up_word.outer_neg};
    span_rnd = {span[W], span} + (W+2)'(bsq_pkg::UnitRound);
    span_ok  = !span[W] && (span != '0);
    dist_neg = {up_word.child_neg[W-1], up_word.child_neg}
             - {up_word.outer_neg[W-1], up_word.outer_neg};
    dist_pos = {up_word.outer_pos[W-1], up_word.outer_pos}
             - {up_word.child_pos[W-1], up_word.child_pos};
    neg_in   = span_ok && !dist_neg[W] && (dist_neg != '0);
    pos_in   = span_ok && !dist_pos[W] && (dist_pos != '0);

    word_nxt.unit      = span_ok
                       ? span_rnd[bsq_pkg::UnitShift +: bsq_pkg::UnitBits]
                       : bsq_pkg::UnitBits'(1);
    word_nxt.rem_neg   = neg_in ? dist_neg[W-1:0] : '0;
    word_nxt.rem_pos   = pos_in ? dist_pos[W-1:0] : '0;
    word_nxt.cnt_neg   = '0;
    word_nxt.cnt_pos   = '0;
    word_nxt.child_neg = up_word.child_neg;
    word_nxt.child_pos = up_word.child_pos;
  end

  assign up_stall  = valid_r && dn_stall;
  assign valid_nxt = up_stall ? valid_r : up_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;

endmodule

### rtl/bsq_cell.sv
// ----------------------------------------------------------------------------
// bsq_cell
// one quotient bit of both saturating divisions, registered
// ----------------------------------------------------------------------------
module bsq_cell #(
  parameter int Bit = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_stall,
  input  bsq_pkg::cell_word_t up_word,
  output logic                dn_valid,
  input  logic                dn_stall,
  output bsq_pkg::cell_word_t dn_word
);

  localparam int W = bsq_pkg::CoordBits;
  localparam int C = bsq_pkg::CmpBits;

  logic                valid_r;
  logic                valid_nxt;
  bsq_pkg::cell_word_t word_r;
  bsq_pkg::cell_word_t word_nxt;

  logic [C-1:0] step;
  logic         take_neg;
  logic         take_pos;

  always_comb begin
    step     = C'(up_word.unit) << Bit;
    take_neg = {1'b0, up_word.rem_neg} >= step;
    take_pos = {1'b0, up_word.rem_pos} >= step;

    word_nxt              = up_word;
    word_nxt.rem_neg      = take_neg ? up_word.rem_neg - step[W-1:0] : up_word.rem_neg;
    word_nxt.rem_pos      = take_pos ? up_word.rem_pos - step[W-1:0] : up_word.rem_pos;
    word_nxt.cnt_neg[Bit] = take_neg;
    word_nxt.cnt_pos[Bit] = take_pos;
  end

  assign up_stall  = valid_r && dn_stall;
  assign valid_nxt = up_stall ? valid_r : up_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the bounding box side quantizer
// ----------------------------------------------------------------------------
// Axis words go in through a queue that a driver drains with random idle
// cycles. Each accepted word is quantized by a local predictor, and the
// expected word waits in a queue for the output. A monitor stalls the output
// at random and compares each accepted result field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int UnitDiv       = 1 << bsq_pkg::UnitShift;
  localparam int RandomAxes    = 1130;
  localparam int IdlePercent   = 16;
  localparam int CalmFirst     = 400;    // no idling on either side in this span
  localparam int CalmLast      = 700;
  localparam int DrainCycles   = 20;     // five-stage pipe plus margin
  localparam int WatchdogLimit = 1000;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  bsq_pkg::in_word_t  in_word   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  bsq_pkg::out_word_t out_word;

  bsq_pkg::in_word_t  axis_queue[$];      // axis words not yet offered
  bsq_pkg::out_word_t quantized_due[$];   // predicted results, oldest first
  int                 axes_sent   = 0;
  int                 axes_done   = 0;
  int                 error_count = 0;
  int                 quiet_edges = 0;

  bbox_side_quantizer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // unit = (span + 15) / 16; each inner corner is counted in whole units,
  // capped at 15, and pushed outward onto the parent's unit grid
  function automatic bsq_pkg::out_word_t quantize_axis(bsq_pkg::in_word_t w);
    int                 span;
    int                 unit;
    int                 gap;
    int                 cnt_neg;
    int                 cnt_pos;
    int                 snap_neg;
    int                 snap_pos;
    bsq_pkg::out_word_t r;
    span     = int'(w.outer_pos) - int'(w.outer_neg) + bsq_pkg::UnitRound;
    cnt_neg  = 0;
    cnt_pos  = 0;
    snap_neg = int'(w.child_neg);
    snap_pos = int'(w.child_pos);
    if (span >= UnitDiv) begin
      unit = span / UnitDiv;
      gap = int'(w.child_neg) - int'(w.outer_neg);
      if (gap > 0) begin
        cnt_neg  = (gap / unit > bsq_pkg::CountMax) ? bsq_pkg::CountMax : gap / unit;
        snap_neg = int'(w.outer_neg) + cnt_neg * unit;
      end
      gap = int'(w.outer_pos) - int'(w.child_pos);
      if (gap > 0) begin
        cnt_pos  = (gap / unit > bsq_pkg::CountMax) ? bsq_pkg::CountMax : gap / unit;
        snap_pos = int'(w.outer_pos) - cnt_pos * unit;
      end
    end
    r.side_code   = {cnt_pos[bsq_pkg::CountBits-1:0], cnt_neg[bsq_pkg::CountBits-1:0]};
    r.snapped_neg = snap_neg[bsq_pkg::CoordBits-1:0];
    r.snapped_pos = snap_pos[bsq_pkg::CoordBits-1:0];
    return r;
  endfunction

  task automatic report(string msg);
    $display("tb: mismatch at result %0d: %0s", axes_done, msg);
    error_count++;
  endtask

  task automatic push_axis(int on, int op, int cn, int cp);
    bsq_pkg::in_word_t w;
    w.outer_neg = on[bsq_pkg::CoordBits-1:0];
    w.outer_pos = op[bsq_pkg::CoordBits-1:0];
    w.child_neg = cn[bsq_pkg::CoordBits-1:0];
    w.child_pos = cp[bsq_pkg::CoordBits-1:0];
    axis_queue.push_back(w);
  endtask

  // driver: a new word is offered only once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        quantized_due.push_back(quantize_axis(in_word));
        axes_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (axis_queue.size() != 0 &&
            ((axes_sent >= CalmFirst && axes_sent < CalmLast) ||
             $urandom_range(99) >= IdlePercent)) begin
          in_word  <= axis_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random output stall, in-order compare
  always @(posedge clk) begin
    bsq_pkg::out_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (quantized_due.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          want = quantized_due.pop_front();
          if (out_word.side_code !== want.side_code)
            report($sformatf("side_code %02h, expected %02h",
                             out_word.side_code, want.side_code));
          if (out_word.snapped_neg !== want.snapped_neg)
            report($sformatf("snapped_neg %0d, expected %0d",
                             out_word.snapped_neg, want.snapped_neg));
          if (out_word.snapped_pos !== want.snapped_pos)
            report($sformatf("snapped_pos %0d, expected %0d",
                             out_word.snapped_pos, want.snapped_pos));
        end
        axes_done++;
      end
      out_stall <= !(axes_done >= CalmFirst && axes_done < CalmLast) &&
                   ($urandom_range(99) < IdlePercent);
    end
  end

  // watchdog: too long without any handshake on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if (quiet_edges >= WatchdogLimit) begin
        $display("tb: errors");
        $finish;
      end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_edges <= 0;
      end else begin
        quiet_edges <= quiet_edges + 1;
      end
    end
  end

  initial begin
    int on;
    int op;
    int len;
    int lo;
    int hi;

    // parent too small or inverted: pass through
    push_axis(0, 0, 0, 0);
    push_axis(-1, -1, -1, -1);
    push_axis(100, -100, 7, -9);
    push_axis(32767, -32768, -32768, 32767);
    push_axis(-32768, -32768, 32767, -32768);
    push_axis(32767, 32767, 32767, 32767);
    // smallest real parent, unit of one
    push_axis(0, 1, 1, 0);
    push_axis(-5, -4, -5, -4);
    // full-range parent, corners on, inside and crossing
    push_axis(-32768, 32767, -32768, 32767);
    push_axis(-32768, 32767, -1, 0);
    push_axis(-32768, 32767, 32767, -32768);
    push_axis(-32768, 32767, -32767, 32766);
    // counts saturate at 15
    push_axis(0, 16, 16, 0);
    push_axis(0, 1000, 999, 1);
    // corners outside the parent
    push_axis(0, 1000, -50, 2000);
    push_axis(-1000, 0, -32768, 32767);
    // child crossing itself
    push_axis(0, 1600, 1500, 100);
    // unit boundaries
    push_axis(0, 17, 3, 14);
    push_axis(0, 16, 1, 15);
    push_axis(10, 42, 11, 41);
    push_axis(-300, 300, -299, 299);

    for (int i = 0; i < RandomAxes; i++) begin
      if ($urandom_range(9) < 7) begin
        // well-formed box, mostly small spans, some up to full range
        case ($urandom_range(2))
          0:       len = int'($urandom_range(40, 1));
          1:       len = int'($urandom_range(2000, 1));
          default: len = int'($urandom_range(65535, 1));
        endcase
        on = int'($urandom_range(65535 - len)) - 32768;
        op = on + len;
        lo = on;
        hi = op;
        if ($urandom_range(9) == 0) begin
          // let a corner stray a little outside
          lo = (on - 8 < -32768) ? -32768 : on - 8;
          hi = (op + 8 > 32767) ? 32767 : op + 8;
        end
        push_axis(on, op, lo + int'($urandom_range(hi - lo)),
                  lo + int'($urandom_range(hi - lo)));
      end else begin
        push_axis(int'($urandom_range(65535)), int'($urandom_range(65535)),
                  int'($urandom_range(65535)), int'($urandom_range(65535)));
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (axis_queue.size() != 0 || in_valid || quantized_due.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (quantized_due.size() != 0)
      report($sformatf("%0d expected words never arrived", quantized_due.size()));
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/bsq_pkg.sv
rtl/bsq_prep.sv
rtl/bsq_cell.sv
rtl/bbox_side_quantizer.sv
test/tb.sv
